// File: hdl/gwsc_pkg.sv
// shared types, register codes and reset values for the grid word search counter
`default_nettype none
package gwsc_pkg;

  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int GRID_W_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int STORE_W    = 3 * CHAR_W;
  localparam int FOUND_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_WORD_FIRST  = 3'd1,
    REG_WORD_SECOND = 3'd2,
    REG_WORD_THIRD  = 3'd3,
    REG_WORD_FOURTH = 3'd4
  } cfg_reg_t;

  localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST = 11'd140;
  localparam logic [CHAR_W-1:0]   WORD_FIRST_RST  = 8'd88;
  localparam logic [CHAR_W-1:0]   WORD_SECOND_RST = 8'd77;
  localparam logic [CHAR_W-1:0]   WORD_THIRD_RST  = 8'd65;
  localparam logic [CHAR_W-1:0]   WORD_FOURTH_RST = 8'd83;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              last_cell;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               count_saturated;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [GRID_W_W-1:0]      grid_width;
    logic [3:0][CHAR_W-1:0]   letters;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic hor_ok;
    logic ver_ok;
  } win_ctl_t;

endpackage
`default_nettype wire

// File: hdl/gwsc_in_if.sv
// input word channel carrying one grid character
`default_nettype none
interface gwsc_in_if
  import gwsc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/gwsc_out_if.sv
// result word channel carrying the match total
`default_nettype none
interface gwsc_out_if
  import gwsc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/gwsc_cfg_if.sv
// configuration write channel
`default_nettype none
interface gwsc_cfg_if
  import gwsc_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/grid_word_search_counter.sv
// top level: raster position control, line store, window compare and total
// a last word passes stage 1 and stage 2, then its total enters the result register
// throughput: one character word per cycle unless stalled, set by the single read and
//   write port pair of the line store; same-column writes in flight reach the next read
// reset: synchronous active-low; registers return to their defaults, counters clear and
//   never-written line store columns read as zero through a fill mark, no clearing pass
`default_nettype none
module grid_word_search_counter
  import gwsc_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gwsc_in_if.sink     in_s,
  gwsc_out_if.source  out_s,
  gwsc_cfg_if.sink    cfg_s
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int WID_W = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W = (WID_W > GRID_W_W) ? WID_W : GRID_W_W;

  cfg_t cfg;

  assign cfg_s.ready = 1'b1;

  gwsc_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_s.valid && cfg_s.ready),
    .wr    (cfg_s.data),
    .cfg   (cfg)
  );

  // raster position
  logic [CMP_W-1:0] gw_ext;
  logic [WID_W-1:0] width_c;
  logic [COL_W-1:0] col_r, col_nxt, col_cur, col_next;
  logic [1:0]       rows_r, rows_nxt;
  logic [WID_W-1:0] col_inc;
  logic             wrap;
  logic             accept;
  logic             advance;

  assign gw_ext = CMP_W'(cfg.grid_width);

  always_comb begin
    if (gw_ext > CMP_W'(MAX_COLUMNS)) begin
      width_c = WID_W'(MAX_COLUMNS);
    end else if (gw_ext == '0) begin
      width_c = WID_W'(1);
    end else begin
      width_c = gw_ext[WID_W-1:0];
    end
  end

  assign col_cur  = (WID_W'(col_r) >= width_c) ? '0 : col_r;
  assign col_inc  = WID_W'(col_cur) + WID_W'(1);
  assign wrap     = col_inc >= width_c;
  assign col_next = wrap ? '0 : col_inc[COL_W-1:0];

  assign accept     = in_s.valid && in_s.ready;
  assign in_s.ready = advance;

  always_comb begin
    col_nxt  = col_r;
    rows_nxt = rows_r;
    if (accept) begin
      if (in_s.data.last_cell) begin
        col_nxt  = '0;
        rows_nxt = '0;
      end else begin
        col_nxt = col_next;
        if (wrap && rows_r != 2'd3) begin
          rows_nxt = rows_r + 2'd1;
        end
      end
    end
  end

  // stage 1: ram data back, window shift and write-back
  logic                 s1_valid_r;
  logic [CHAR_W-1:0]    s1_char_r;
  logic                 s1_last_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 s1_hor_r;
  logic                 s1_ver_r;
  logic                 s1_fwd_r;
  logic [STORE_W-1:0]   s1_fwd_data_r;
  logic                 s1_fill_ok_r;
  logic [WID_W-1:0]     fill_r;
  logic [STORE_W-1:0]   ram_rdata;
  logic [STORE_W-1:0]   stored;
  logic [STORE_W-1:0]   wr_data;
  logic                 we;
  logic [FOUND_W-1:0]   found;
  win_ctl_t             win_ctl;

  assign stored  = s1_fwd_r ? s1_fwd_data_r : (s1_fill_ok_r ? ram_rdata : '0);
  assign wr_data = {stored[2*CHAR_W-1:0], s1_char_r};
  assign we      = s1_valid_r && advance;

  gwsc_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_row_store (
    .clk   (clk),
    .we    (we),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  assign win_ctl.shift  = we;
  assign win_ctl.hor_ok = s1_hor_r;
  assign win_ctl.ver_ok = s1_ver_r;

  gwsc_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .stored  (stored),
    .ch      (s1_char_r),
    .letters (cfg.letters),
    .found   (found)
  );

  // stage 2: saturating total and result register
  logic                 s2_valid_r;
  logic [FOUND_W-1:0]   s2_found_r;
  logic                 s2_last_r;
  logic [COUNT_W-1:0]   total_r, total_nxt;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   tot_new;
  logic                 out_valid_r;
  out_word_t            out_r;

  assign advance = !(s2_valid_r && s2_last_r && out_valid_r && !out_s.ready);
  assign sum     = {1'b0, total_r} + (COUNT_W+1)'(s2_found_r);
  assign tot_new = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  always_comb begin
    total_nxt = total_r;
    if (advance && s2_valid_r) begin
      total_nxt = s2_last_r ? '0 : tot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_r      <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      rows_r  <= rows_nxt;
      total_r <= total_nxt;
      if (we && WID_W'(s1_col_r) >= fill_r) begin
        fill_r <= WID_W'(s1_col_r) + WID_W'(1);
      end
      if (advance) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
      end
      if (advance && s2_valid_r && s2_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r     <= in_s.data.cell_char;
      s1_last_r     <= in_s.data.last_cell;
      s1_col_r      <= col_cur;
      s1_hor_r      <= col_cur >= COL_W'(3);
      s1_ver_r      <= rows_r == 2'd3;
      s1_fwd_r      <= s1_valid_r && (s1_col_r == col_cur);
      s1_fwd_data_r <= wr_data;
      s1_fill_ok_r  <= WID_W'(col_cur) < fill_r;
    end
    if (advance) begin
      s2_found_r <= found;
      s2_last_r  <= s1_last_r;
    end
    if (advance && s2_valid_r && s2_last_r) begin
      out_r.match_count     <= tot_new;
      out_r.count_saturated <= tot_new == '1;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_r;

`ifndef SYNTHESIS
  a_last_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_s.data.last_cell |=> col_r == '0 && rows_r == '0)
    else $error("raster position not cleared after last word");

  a_fwd_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> $past(s1_valid_r))
    else $error("forward taken without a write in flight");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WID_W'(MAX_COLUMNS))
    else $error("fill mark beyond line store depth");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s2_valid_r && !s2_last_r |=> total_r >= $past(total_r))
    else $error("running total decreased inside a grid");
`endif

endmodule
`default_nettype wire

// File: hdl/gwsc_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module gwsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/gwsc_regs.sv
// configuration registers: grid width and the four word letters
`default_nettype none
module gwsc_regs
  import gwsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire cfg_word_t wr,
  output cfg_t           cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr.index)
        REG_GRID_WIDTH:  cfg_nxt.grid_width = wr.value[GRID_W_W-1:0];
        REG_WORD_FIRST:  cfg_nxt.letters[0] = wr.value[CHAR_W-1:0];
        REG_WORD_SECOND: cfg_nxt.letters[1] = wr.value[CHAR_W-1:0];
        REG_WORD_THIRD:  cfg_nxt.letters[2] = wr.value[CHAR_W-1:0];
        REG_WORD_FOURTH: cfg_nxt.letters[3] = wr.value[CHAR_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width <= GRID_WIDTH_RST;
      cfg_r.letters[0] <= WORD_FIRST_RST;
      cfg_r.letters[1] <= WORD_SECOND_RST;
      cfg_r.letters[2] <= WORD_THIRD_RST;
      cfg_r.letters[3] <= WORD_FOURTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: hdl/gwsc_window.sv
// 4 by 4 character window with line compares in both reading directions
`default_nettype none
module gwsc_window
  import gwsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire win_ctl_t               ctl,
  input  wire logic [STORE_W-1:0]     stored,
  input  wire logic [CHAR_W-1:0]      ch,
  input  wire logic [3:0][CHAR_W-1:0] letters,
  output logic      [FOUND_W-1:0]     found
);

  logic [CHAR_W-1:0] w_r   [16];
  logic [CHAR_W-1:0] w_nxt [16];

  function automatic logic [1:0] line_hits(
    input logic [CHAR_W-1:0]      a,
    input logic [CHAR_W-1:0]      b,
    input logic [CHAR_W-1:0]      c,
    input logic [CHAR_W-1:0]      d,
    input logic [3:0][CHAR_W-1:0] l
  );
    logic fwd;
    logic rev;
    fwd = (a == l[0]) && (b == l[1]) && (c == l[2]) && (d == l[3]);
    rev = (d == l[0]) && (c == l[1]) && (b == l[2]) && (a == l[3]);
    return 2'(fwd) + 2'(rev);
  endfunction

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        w_nxt[r*4+c] = w_r[r*4+c+1];
      end
    end
    w_nxt[3]  = stored[3*CHAR_W-1:2*CHAR_W];
    w_nxt[7]  = stored[2*CHAR_W-1:CHAR_W];
    w_nxt[11] = stored[CHAR_W-1:0];
    w_nxt[15] = ch;
  end

  logic [1:0] hor_hits;
  logic [1:0] ver_hits;
  logic [1:0] dia_hits;
  logic [1:0] anti_hits;

  always_comb begin
    hor_hits  = line_hits(w_nxt[12], w_nxt[13], w_nxt[14], w_nxt[15], letters);
    ver_hits  = line_hits(w_nxt[3], w_nxt[7], w_nxt[11], w_nxt[15], letters);
    dia_hits  = line_hits(w_nxt[0], w_nxt[5], w_nxt[10], w_nxt[15], letters);
    anti_hits = line_hits(w_nxt[12], w_nxt[9], w_nxt[6], w_nxt[3], letters);
    found = '0;
    if (ctl.hor_ok) begin
      found = found + FOUND_W'(hor_hits);
    end
    if (ctl.ver_ok) begin
      found = found + FOUND_W'(ver_hits);
    end
    if (ctl.hor_ok && ctl.ver_ok) begin
      found = found + FOUND_W'(dia_hits) + FOUND_W'(anti_hits);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      w_r <= w_nxt;
    end
  end

endmodule
`default_nettype wire
